// ===== sv/upsbb_pkg.sv =====
// ----------------------------------------------------------------------------
// upsbb_pkg: shared types for the point set bounding box block
// Holds the control word that the sequencer hands to the box unit.
// ----------------------------------------------------------------------------
`default_nettype none

package upsbb_pkg;

   // Command to the box unit; clear wins over update.
   typedef struct packed {
      logic clear;   // zero the corners (start of a new blob)
      logic update;  // fold the current point into the box
      logic first;   // store was empty: load corners from the point
   } box_ctrl_type;

endpackage

`default_nettype wire

// ===== sv/upsbb_store.sv =====
// ----------------------------------------------------------------------------
// upsbb_store: point memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module upsbb_store #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/upsbb_box.sv =====
// ----------------------------------------------------------------------------
// upsbb_box: bounding box corners
// Clear, load from the first point, or widen by min/max of the point.
// ----------------------------------------------------------------------------
`default_nettype none

module upsbb_box #(
   parameter int COORD_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire upsbb_pkg::box_ctrl_type ctrl,
   input  wire logic [COORD_BITS-1:0] point_x,
   input  wire logic [COORD_BITS-1:0] point_y,
   output      logic [COORD_BITS-1:0] min_x,
   output      logic [COORD_BITS-1:0] min_y,
   output      logic [COORD_BITS-1:0] max_x,
   output      logic [COORD_BITS-1:0] max_y
);

   logic [COORD_BITS-1:0] min_x_ff, min_y_ff, max_x_ff, max_y_ff;
   logic [COORD_BITS-1:0] min_x_in, min_y_in, max_x_in, max_y_in;

   always_comb begin
      min_x_in = min_x_ff;
      min_y_in = min_y_ff;
      max_x_in = max_x_ff;
      max_y_in = max_y_ff;
      priority if (ctrl.clear) begin
         min_x_in = '0;
         min_y_in = '0;
         max_x_in = '0;
         max_y_in = '0;
      end else if (ctrl.update && ctrl.first) begin
         min_x_in = point_x;
         min_y_in = point_y;
         max_x_in = point_x;
         max_y_in = point_y;
      end else if (ctrl.update) begin
         if (point_x < min_x_ff) min_x_in = point_x;
         if (point_y < min_y_ff) min_y_in = point_y;
         if (point_x > max_x_ff) max_x_in = point_x;
         if (point_y > max_y_ff) max_y_in = point_y;
      end else begin
         // hold the corners
         min_x_in = min_x_ff;
         min_y_in = min_y_ff;
         max_x_in = max_x_ff;
         max_y_in = max_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff <= '0;
         min_y_ff <= '0;
         max_x_ff <= '0;
         max_y_ff <= '0;
      end else begin
         min_x_ff <= min_x_in;
         min_y_ff <= min_y_in;
         max_x_ff <= max_x_in;
         max_y_ff <= max_y_in;
      end
   end

   assign min_x = min_x_ff;
   assign min_y = min_y_ff;
   assign max_x = max_x_ff;
   assign max_y = max_y_ff;

endmodule

`default_nettype wire

// ===== sv/unique_point_set_bounding_box.sv =====
// ----------------------------------------------------------------------------
// unique_point_set_bounding_box: distinct point store with bounding box
// Rejects duplicate points, stores new ones and tracks their bounding box.
// ----------------------------------------------------------------------------
// Each input word carries one pixel point. The block compares it with every
// stored point, one memory read per cycle through a single comparator, and
// rejects a duplicate. A new point is written to the store, the count rises and
// the box is loaded from it (empty store) or widened by min/max. A full store
// drops the point and flags store_full. tuser set empties the blob before the
// point is handled; tlast closes a batch, and the result word of that item says
// whether every point of the batch was inserted. An item occupies the block from
// its acceptance through the scan, ST_DECIDE and ST_FINISH to the next acceptance;
// the scan reads every stored point (count as the scan sees it, zero after tuser)
// unless a duplicate ends it early, through the point memory's single read port.
// req_tready is high only between items. A finished result waits in the output
// register without holding off the next input word, but that next item holds in
// ST_FINISH until the register frees, so a result stall lengthens it. The store
// needs no clearing after reset: only entries below the count are ever read.
`default_nettype none

module unique_point_set_bounding_box #(
   parameter int MAX_POINTS = 1024,
   parameter int COORD_BITS = 16,
   localparam int CNT_W     = $clog2(MAX_POINTS + 1),
   localparam int REQ_BITS  = 2 * COORD_BITS,
   localparam int REQ_W     = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS  = 3 + CNT_W + 6 * COORD_BITS,
   localparam int RSP_W     = ((RSP_BITS + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // input point stream
   input  wire logic             req_tvalid,
   output      logic             req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,  // point_x, point_y
   input  wire logic             req_tuser,  // start_new
   input  wire logic             req_tlast,  // batch_last
   // result stream
   output      logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   // inserted, store_full, point_count, box_min_x, box_min_y, box_max_x,
   // box_max_y, box_width, box_height, batch_all_inserted, zero fill
   output      logic [RSP_W-1:0] rsp_tdata
);

   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [COORD_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic                  last_ff, last_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic                  dup_ff, dup_in;
   logic                  batch_ok_ff, batch_ok_in;
   logic                  ins_ff, ins_in;
   logic                  full_ff, full_in;
   logic                  all_ok_ff, all_ok_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]      rsp_data_ff, rsp_data_in;

   logic                  req_accept;
   logic                  rd_en, wr_en, hit, load_rsp;
   logic                  dec_full, dec_ins;
   logic [REQ_BITS-1:0]   rd_data;
   logic [COORD_BITS-1:0] min_x, min_y, max_x, max_y;
   logic [COORD_BITS-1:0] box_w, box_h;
   upsbb_pkg::box_ctrl_type box_ctrl;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // single comparator shared by every stored point
   assign hit = (rd_data == {py_ff, px_ff});

   assign dec_full = !dup_ff && (count_ff == CNT_W'(MAX_POINTS));
   assign dec_ins  = !dup_ff && !dec_full;

   // corners never cross, so the plain difference is the absolute one
   assign box_w = max_x - min_x;
   assign box_h = max_y - min_y;

   assign load_rsp = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in    = state_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      last_in     = last_ff;
      count_in    = count_ff;
      rd_idx_in   = rd_idx_ff;
      rd_pend_in  = rd_pend_ff;
      dup_in      = dup_ff;
      batch_ok_in = batch_ok_ff;
      ins_in      = ins_ff;
      full_in     = full_ff;
      all_ok_in   = all_ok_ff;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               px_in      = req_tdata[COORD_BITS-1:0];
               py_in      = req_tdata[REQ_BITS-1:COORD_BITS];
               last_in    = req_tlast;
               count_in   = req_tuser ? '0 : count_ff;
               rd_idx_in  = '0;
               rd_pend_in = 1'b0;
               dup_in     = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // issue one read per cycle, compare the word read the cycle before
            rd_pend_in = 1'b0;
            priority if (rd_pend_ff && hit) begin
               dup_in   = 1'b1;
               state_in = ST_DECIDE;
            end else if (rd_idx_ff != count_ff) begin
               rd_en      = 1'b1;
               rd_idx_in  = rd_idx_ff + 1'b1;
               rd_pend_in = 1'b1;
            end else begin
               // every stored point compared without a hit
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            wr_en     = dec_ins;
            count_in  = dec_ins ? count_ff + 1'b1 : count_ff;
            ins_in    = dec_ins;
            full_in   = dec_full;
            all_ok_in = last_ff && batch_ok_ff && dec_ins;
            if (last_ff) begin
               batch_ok_in = 1'b1;
            end else begin
               batch_ok_in = batch_ok_ff && dec_ins;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      box_ctrl.clear  = req_accept && req_tuser;
      box_ctrl.update = (state_ff == ST_DECIDE) && dec_ins;
      box_ctrl.first  = (count_ff == '0);
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({all_ok_ff, box_h, box_w, max_y, max_x, min_y, min_x,
                                count_ff, full_ff, ins_ff});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         dup_ff       <= 1'b0;
         batch_ok_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_pend_ff   <= rd_pend_in;
         dup_ff       <= dup_in;
         batch_ok_ff  <= batch_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      px_ff       <= px_in;
      py_ff       <= py_in;
      last_ff     <= last_in;
      rd_idx_ff   <= rd_idx_in;
      ins_ff      <= ins_in;
      full_ff     <= full_in;
      all_ok_ff   <= all_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   upsbb_store #(
      .DEPTH  (MAX_POINTS),
      .DATA_W (REQ_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({py_ff, px_ff}),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   upsbb_box #(
      .COORD_BITS (COORD_BITS)
   ) u_box (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (box_ctrl),
      .point_x (px_ff),
      .point_y (py_ff),
      .min_x   (min_x),
      .min_y   (min_y),
      .max_x   (max_x),
      .max_y   (max_y)
   );

   // the count never passes the store depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count beyond store depth");

   // the scan never reads past the stored points
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> rd_idx_ff <= count_ff)
      else $error("scan index beyond point count");

   // a point is never both inserted and rejected as full
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH |-> !(ins_ff && full_ff))
      else $error("inserted and store_full both set");

   // a nonempty blob keeps its corners ordered
   a_box_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && count_ff != '0) |-> (min_x <= max_x && min_y <= max_y))
      else $error("bounding box corners crossed");

   // an inserted point raises the count by one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && dec_ins) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("count did not advance on insert");

endmodule

`default_nettype wire
